@@ src/spd_pkg.sv @@
package spd_pkg;

    // receive phases
    typedef enum logic [3:0] {
        PH_WAIT_SYNC = 4'd0,
        PH_IDLE      = 4'd1,
        PH_STROBE2   = 4'd2,
        PH_SYNC2     = 4'd3,
        PH_SYNC3     = 4'd4,
        PH_SYNC4     = 4'd5,
        PH_REPLY_DUE = 4'd6,
        PH_HEADER    = 4'd7,
        PH_PAYLOAD   = 4'd8
    } phase_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNEXPECTED  = 3'd1,
        ST_HDR_CRC     = 3'd2,
        ST_PAY_CRC     = 3'd3,
        ST_GOOD        = 3'd4,
        ST_IGNORED     = 3'd5,
        ST_WRONG_STATE = 3'd6
    } status_t;

    // item operations
    localparam logic OP_RX_BYTE    = 1'b0;
    localparam logic OP_REPLY_SENT = 1'b1;

    // framing bytes
    localparam logic [7:0] STROBE_0    = 8'hA5;
    localparam logic [7:0] STROBE_TAIL = 8'h63;
    localparam logic [7:0] SYNC_0      = 8'hD3;
    localparam logic [7:0] SYNC_1      = 8'h74;
    localparam logic [7:0] SYNC_2      = 8'hE5;
    localparam logic [7:0] SYNC_3      = 8'h52;

    // crc constants
    localparam logic [7:0]  CRC8_POLY  = 8'h07;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] frame_id;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        last_of_packet;
        logic        sync_reply_due;
        logic        synced;
    } result_t;

    // one byte through crc-8, msb first
    function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC8_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    // one byte through crc-16 ccitt, msb first
    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            v = v[15] ? ({v[14:0], 1'b0} ^ CRC16_POLY) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

endpackage

@@ src/spd_core.sv @@
module spd_core
    import spd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    output result_t result
);

    phase_t      phase_reg, phase_next;
    logic        synced_reg, synced_next;
    logic [2:0]  hcount_reg, hcount_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  pcount_reg, pcount_next;
    logic [15:0] id_reg, id_next;
    logic [7:0]  crc8_reg, crc8_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [15:0] crc16_reg, crc16_next;

    logic [7:0]  b;
    logic [7:0]  crc8_upd;
    logic [15:0] crc16_upd;
    logic        finish;
    phase_t      sync_fail;

    assign b         = item.rx_byte;
    assign crc8_upd  = crc8_step(crc8_reg, b);
    assign crc16_upd = crc16_step(crc16_reg, b);
    assign sync_fail = synced_reg ? PH_IDLE : PH_WAIT_SYNC;

    // state registers, updated on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT_SYNC;
            synced_reg <= 1'b0;
            hcount_reg <= '0;
            length_reg <= '0;
            pcount_reg <= '0;
            id_reg     <= '0;
            crc8_reg   <= '0;
            rcrc_reg   <= '0;
            crc16_reg  <= CRC16_INIT;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            synced_reg <= synced_next;
            hcount_reg <= hcount_next;
            length_reg <= length_next;
            pcount_reg <= pcount_next;
            id_reg     <= id_next;
            crc8_reg   <= crc8_next;
            rcrc_reg   <= rcrc_next;
            crc16_reg  <= crc16_next;
        end
    end

    // next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        synced_next = synced_reg;
        hcount_next = hcount_reg;
        length_next = length_reg;
        pcount_next = pcount_reg;
        id_next     = id_reg;
        crc8_next   = crc8_reg;
        rcrc_next   = rcrc_reg;
        crc16_next  = crc16_reg;
        finish      = 1'b0;
        result      = '0;
        result.status = ST_OK;

        if (item.operation == OP_REPLY_SENT)
        begin
            if (phase_reg == PH_REPLY_DUE)
            begin
                phase_next  = PH_IDLE;
                synced_next = 1'b1;
                hcount_next = '0;
                length_next = '0;
                pcount_next = '0;
                id_next     = '0;
                crc8_next   = '0;
                rcrc_next   = '0;
                crc16_next  = CRC16_INIT;
            end
            else if (phase_reg != PH_IDLE)
            begin
                result.status = ST_WRONG_STATE;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (b == STROBE_0)
                        phase_next = PH_STROBE2;
                    else if (b == SYNC_0)
                        phase_next = PH_SYNC2;
                    else
                        result.status = ST_UNEXPECTED;
                end
                PH_STROBE2:
                begin
                    if (b == STROBE_TAIL)
                    begin
                        phase_next  = PH_HEADER;
                        hcount_next = '0;
                        length_next = '0;
                        pcount_next = '0;
                        id_next     = '0;
                        crc8_next   = '0;
                        rcrc_next   = '0;
                        crc16_next  = CRC16_INIT;
                    end
                    else
                    begin
                        phase_next    = PH_IDLE;
                        result.status = ST_UNEXPECTED;
                    end
                end
                PH_SYNC2:
                begin
                    if (b == SYNC_1)
                        phase_next = PH_SYNC3;
                    else
                    begin
                        phase_next    = sync_fail;
                        result.status = ST_UNEXPECTED;
                    end
                end
                PH_SYNC3:
                begin
                    if (b == SYNC_2)
                        phase_next = PH_SYNC4;
                    else
                    begin
                        phase_next    = sync_fail;
                        result.status = ST_UNEXPECTED;
                    end
                end
                PH_SYNC4:
                begin
                    if (b == SYNC_3)
                        phase_next = PH_REPLY_DUE;
                    else
                    begin
                        phase_next    = sync_fail;
                        result.status = ST_UNEXPECTED;
                    end
                end
                PH_REPLY_DUE:
                begin
                    result.status = ST_IGNORED;
                end
                PH_HEADER:
                begin
                    // crc-16 covers id, length and crc-8
                    if (hcount_reg < 3'd4)
                        crc16_next = crc16_upd;
                    case (hcount_reg)
                        3'd0:
                        begin
                            id_next   = {b, 8'h00};
                            crc8_next = crc8_upd;
                        end
                        3'd1:
                        begin
                            id_next   = {id_reg[15:8], b};
                            crc8_next = crc8_upd;
                        end
                        3'd2:
                        begin
                            length_next = b;
                            crc8_next   = crc8_upd;
                        end
                        3'd3:
                        begin
                            if (b != crc8_reg)
                            begin
                                result.status = ST_HDR_CRC;
                                phase_next    = PH_IDLE;
                                finish        = 1'b1;
                            end
                        end
                        3'd4:
                        begin
                            rcrc_next = {b, 8'h00};
                        end
                        default:
                        begin
                            rcrc_next = {rcrc_reg[15:8], b};
                            if (length_reg == 8'd0)
                            begin
                                // empty packet: check right away
                                result.status = (crc16_reg == rcrc_next) ? ST_GOOD
                                                                         : ST_PAY_CRC;
                                result.last_of_packet = 1'b1;
                                phase_next = PH_IDLE;
                                finish     = 1'b1;
                            end
                            else
                            begin
                                pcount_next = '0;
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    endcase
                    hcount_next = hcount_reg + 3'd1;
                end
                PH_PAYLOAD:
                begin
                    crc16_next           = crc16_upd;
                    result.payload_byte  = b;
                    result.payload_valid = 1'b1;
                    pcount_next          = pcount_reg + 8'd1;
                    if (pcount_next >= length_reg)
                    begin
                        result.status = (crc16_upd == rcrc_reg) ? ST_GOOD : ST_PAY_CRC;
                        result.last_of_packet = 1'b1;
                        phase_next = PH_IDLE;
                        finish     = 1'b1;
                    end
                end
                default:
                begin
                    // waiting for sync, and any unknown phase
                    if (b == SYNC_0)
                        phase_next = PH_SYNC2;
                    else
                    begin
                        phase_next    = PH_WAIT_SYNC;
                        result.status = ST_UNEXPECTED;
                    end
                end
            endcase
        end

        // outputs show the packet before it is cleared
        result.frame_id       = id_next;
        result.payload_length = length_next;
        result.sync_reply_due = (phase_next == PH_REPLY_DUE);
        result.synced         = synced_next;

        if (finish)
        begin
            hcount_next = '0;
            length_next = '0;
            pcount_next = '0;
            id_next     = '0;
            crc8_next   = '0;
            rcrc_next   = '0;
            crc16_next  = CRC16_INIT;
        end
    end

endmodule

@@ src/spd_out_reg.sv @@
module spd_out_reg
    import spd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t din,
    output logic    can_load,
    output logic    valid,
    input  logic    ready,
    output result_t dout
);

    logic    valid_reg;
    result_t data_reg;

    // free when empty or being drained this cycle
    assign can_load = !valid_reg || ready;
    assign valid    = valid_reg;
    assign dout     = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (ready)
            valid_reg <= 1'b0;
    end

    // result data
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= din;
    end

endmodule

@@ src/sync_and_packet_deframer.sv @@
// channel   signals                                    payload
// item      item_valid, item_ready, item               item_t: operation, rx_byte
// result    result_valid, result_ready, result         result_t: status .. synced
//
// one result per item, registered, in the cycle after the item transfer; the crc
// updates are combinational, so an item can be taken every cycle unless stalled.
// the output register lets a new item in on the same edge the old result leaves.
// reset leaves the block waiting for sync with no result pending.
// a stalled result holds item_ready low until it is taken.
module sync_and_packet_deframer
    import spd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic    accept;
    result_t core_result;

    assign accept = item_valid && item_ready;

    // framing state and crc checks
    spd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .result (core_result)
    );

    // result register
    spd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .din      (core_result),
        .can_load (item_ready),
        .valid    (result_valid),
        .ready    (result_ready),
        .dout     (result)
    );

    // a stalled result blocks new items
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !item_ready)
        else $error("item taken while result stalled");

    // payload bytes only with ok or a packet end status
    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.payload_valid) |->
        (result.status == ST_OK || result.status == ST_GOOD || result.status == ST_PAY_CRC))
        else $error("payload byte with bad status");

    // packet end reports good or payload crc error
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_of_packet) |->
        (result.status == ST_GOOD || result.status == ST_PAY_CRC))
        else $error("packet end with bad status");

    // reply due only after the last sync byte or while waiting
    a_reply_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.sync_reply_due) |->
        (result.status == ST_OK || result.status == ST_IGNORED ||
         result.status == ST_WRONG_STATE))
        else $error("reply due with bad status");

endmodule
